// ===== rtl/core/assert_macros.svh =====
// assertion macros for the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/core/e2q_pkg.sv =====
// types, constants and helpers for the euler to quaternion core
package e2q_pkg;
  localparam int AngleWidth = 16;
  localparam int QuatWidth = 16;
  localparam int Ifrac = 30;
  localparam int Steps = 30;
  localparam int IW = 34;
  localparam logic signed [IW-1:0] PiQ = 34'sd3373259426;
  localparam logic signed [IW-1:0] PiHalfQ = 34'sd1686629713;
  localparam logic signed [IW-1:0] CordicK = 34'sd652032874;

  typedef struct packed {
    logic signed [AngleWidth-1:0] roll_angle;
    logic signed [AngleWidth-1:0] pitch_angle;
    logic signed [AngleWidth-1:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [QuatWidth-1:0] quat_w;
    logic signed [QuatWidth-1:0] quat_x;
    logic signed [QuatWidth-1:0] quat_y;
    logic signed [QuatWidth-1:0] quat_z;
  } out_item_t;

  typedef struct packed {
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] z;
    logic neg;
  } rot_t;

  typedef struct packed {
    rot_t roll;
    rot_t pitch;
    rot_t yaw;
  } cell_data_t;

  function automatic logic signed [IW-1:0] atan_entry(input logic [4:0] i);
    logic signed [IW-1:0] r;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      default: r = IW'(64'sd1 <<< (Ifrac - int'(i)));
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/core/e2q_cell.sv =====
// one cordic step for all three angles
module e2q_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [4:0]              step,
  input  logic                    valid_in,
  input  e2q_pkg::cell_data_t     data_in,
  input  logic                    advance,
  output logic                    valid_out,
  output e2q_pkg::cell_data_t     data_out
);
  function automatic e2q_pkg::rot_t rotate(input e2q_pkg::rot_t a, input logic [4:0] s);
    e2q_pkg::rot_t r;
    r = a;
    if (!a.z[e2q_pkg::IW-1]) begin
      r.x = a.x - (a.y >>> s);
      r.y = a.y + (a.x >>> s);
      r.z = a.z - e2q_pkg::atan_entry(s);
    end else begin
      r.x = a.x + (a.y >>> s);
      r.y = a.y - (a.x >>> s);
      r.z = a.z + e2q_pkg::atan_entry(s);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_out.roll <= rotate(data_in.roll, step);
      data_out.pitch <= rotate(data_in.pitch, step);
      data_out.yaw <= rotate(data_in.yaw, step);
    end
  end
endmodule

// ===== rtl/core/e2q_mix.sv =====
// products, rounding and saturation of the quaternion components
module e2q_mix (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    valid_in,
  input  e2q_pkg::cell_data_t     data_in,
  output logic                    valid_out,
  output e2q_pkg::out_item_t      data_out
);
  localparam int IW = e2q_pkg::IW;
  localparam int QW = e2q_pkg::QuatWidth;
  localparam int Sh = e2q_pkg::Ifrac - (QW - 2);

  logic signed [IW-1:0] sr, cr, sp, cp, sy, cy;
  logic signed [IW-1:0] s1r, c1r, s1y, c1y;
  logic signed [IW-1:0] cc, ss, sc, cs;
  logic signed [IW-1:0] t0, t1, t2, t3, t4, t5, t6, t7;
  logic signed [IW+1:0] w, x, y, z;
  logic [3:0] vld;

  function automatic logic signed [IW-1:0] fix(input logic signed [IW-1:0] v, input logic n);
    return n ? -v : v;
  endfunction

  function automatic logic signed [IW-1:0] mulq(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    logic signed [2*IW-1:0] p;
    p = a * b;
    return IW'(p >>> e2q_pkg::Ifrac);
  endfunction

  function automatic logic signed [QW-1:0] to_out(input logic signed [IW+1:0] v);
    logic signed [IW+1:0] r;
    logic signed [IW+1:0] one;
    one = (IW+2)'(1) <<< (QW - 2);
    r = (v + ((IW+2)'(1) <<< (Sh - 1))) >>> Sh;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return QW'(r);
  endfunction

  always_comb begin
    sr = fix(data_in.roll.y, data_in.roll.neg);
    cr = fix(data_in.roll.x, data_in.roll.neg);
    sp = fix(data_in.pitch.y, data_in.pitch.neg);
    cp = fix(data_in.pitch.x, data_in.pitch.neg);
    sy = fix(data_in.yaw.y, data_in.yaw.neg);
    cy = fix(data_in.yaw.x, data_in.yaw.neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cc <= mulq(cr, cp);
      ss <= mulq(sr, sp);
      sc <= mulq(sr, cp);
      cs <= mulq(cr, sp);
      s1r <= sr; c1r <= cr; s1y <= sy; c1y <= cy;
      t0 <= mulq(cc, c1y);
      t1 <= mulq(ss, s1y);
      t2 <= mulq(sc, c1y);
      t3 <= mulq(cs, s1y);
      t4 <= mulq(cs, c1y);
      t5 <= mulq(sc, s1y);
      t6 <= mulq(cc, s1y);
      t7 <= mulq(ss, c1y);
      w <= (IW+2)'(t0) + (IW+2)'(t1);
      x <= (IW+2)'(t2) - (IW+2)'(t3);
      y <= (IW+2)'(t4) + (IW+2)'(t5);
      z <= (IW+2)'(t6) - (IW+2)'(t7);
      data_out.quat_w <= to_out(w);
      data_out.quat_x <= to_out(x);
      data_out.quat_y <= to_out(y);
      data_out.quat_z <= to_out(z);
    end
  end

  assign valid_out = vld[3];
endmodule

// ===== rtl/core/euler_to_quaternion_top.sv =====
// euler angle to quaternion converter top level
// pipeline: 1 fold stage + 30 cordic cells + 4 product stages
// throughput: one item per cycle while the output is not stalled, set by the row of cordic cells
// the whole pipeline advances when the output register is free or taken
// reset clears the valid bits only, no clearing pass
`include "assert_macros.svh"
module euler_to_quaternion_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  e2q_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output e2q_pkg::out_item_t   out_data
);
  localparam int N = e2q_pkg::Steps;
  localparam int IW = e2q_pkg::IW;
  localparam int AW = e2q_pkg::AngleWidth;

  logic advance;
  logic [N:0] v;
  e2q_pkg::cell_data_t d [N+1];
  e2q_pkg::cell_data_t fold;

  function automatic e2q_pkg::rot_t prep(input logic signed [AW-1:0] a);
    e2q_pkg::rot_t r;
    logic signed [IW-1:0] h;
    h = IW'(a) <<< (e2q_pkg::Ifrac - (AW - 3));
    r.x = e2q_pkg::CordicK;
    r.y = '0;
    r.neg = 1'b0;
    if (h > e2q_pkg::PiHalfQ) begin
      h = h - e2q_pkg::PiQ;
      r.neg = 1'b1;
    end else if (h < -e2q_pkg::PiHalfQ) begin
      h = h + e2q_pkg::PiQ;
      r.neg = 1'b1;
    end
    r.z = h;
    return r;
  endfunction

  assign advance = !out_valid || out_ready;
  assign in_ready = advance;

  always_comb begin
    fold.roll = prep(in_data.roll_angle);
    fold.pitch = prep(in_data.pitch_angle);
    fold.yaw = prep(in_data.yaw_angle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d[0] <= fold;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    e2q_cell u_cell (
      .clk(clk), .rst(rst), .step(5'(i)), .valid_in(v[i]), .data_in(d[i]),
      .advance(advance), .valid_out(v[i+1]), .data_out(d[i+1])
    );
  end

  e2q_mix u_mix (
    .clk(clk), .rst(rst), .advance(advance), .valid_in(v[N]), .data_in(d[N]),
    .valid_out(out_valid), .data_out(out_data)
  );

  `ASSERT_IMPL(a_ready_free, clk, rst, !out_valid |-> in_ready)
  `ASSERT_IMPL(a_stall_hold, clk, rst, (out_valid && !out_ready) |=> $stable(v))
  `ASSERT_NORST(a_reset_empty, clk, rst |=> !out_valid && (v == '0))
endmodule
